>>> design/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

   // pixel and result widths
   localparam int CHANNEL_BITS  = 8;
   localparam int FRACTION_BITS = 16;

   // hue works in sixths of a turn
   localparam int TURN_SECTORS  = 6;

   // 6 * delta stays below 2^(CHANNEL_BITS + 3)
   localparam int HUE_DIV_BITS  = CHANNEL_BITS + 3;

   // input pixel
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rhc_req_type;

   // output hsv triple
   typedef struct packed {
      logic [FRACTION_BITS-1:0] hue;
      logic [FRACTION_BITS:0]   saturation;
      logic [CHANNEL_BITS-1:0]  brightness;
   } rhc_rsp_type;

   // state of both long divisions as it travels down the pipe
   typedef struct packed {
      logic [CHANNEL_BITS-1:0]  brightness;
      logic [CHANNEL_BITS-1:0]  sat_div;
      logic [CHANNEL_BITS-1:0]  sat_rem;
      logic [FRACTION_BITS:0]   sat_quo;
      logic [HUE_DIV_BITS-1:0]  hue_div;
      logic [HUE_DIV_BITS-1:0]  hue_rem;
      logic [FRACTION_BITS-1:0] hue_quo;
   } rhc_stage_type;

endpackage

>>> design/rgb_to_hsv_converter_top.sv
`timescale 1ns / 1ps

// RGB to HSV converter. Takes one pixel per clock while req_stall is low and returns
// hue, saturation and brightness from the last stage register. One front stage finds
// the largest and smallest channel and the hue sector, then FRACTION_BITS stages each
// produce one quotient bit of both the saturation and the hue division. Each stage
// holds its own valid bit and moves whenever the stage after it is empty or moving,
// so bubbles close up and input transfers continue while a result waits on rsp_stall
// as long as some stage is still empty.
module rgb_to_hsv_converter_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rhc_pkg::rhc_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rhc_pkg::rhc_rsp_type rsp_payload
);

   localparam int F = rhc_pkg::FRACTION_BITS;

   logic [F:0]             stage_valid;
   logic [F:0]             stage_en;
   rhc_pkg::rhc_stage_type stage_data [0:F];

   // advance chain: a stage moves if it is empty or its successor moves
   assign stage_en[F] = !stage_valid[F] || !rsp_stall;

   genvar k;
   generate
      for (k = 0; k < F; k++) begin : g_en
         assign stage_en[k] = !stage_valid[k] || stage_en[k+1];
      end
   endgenerate

   // sector and range stage
   rhc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (stage_en[0]),
      .up_valid (req_valid),
      .up_data  (req_payload),
      .dn_valid (stage_valid[0]),
      .dn_data  (stage_data[0])
   );

   // one quotient bit per stage
   generate
      for (k = 1; k <= F; k++) begin : g_div
         rhc_div_step u_step (
            .clock    (clock),
            .reset    (reset),
            .enable   (stage_en[k]),
            .up_valid (stage_valid[k-1]),
            .up_data  (stage_data[k-1]),
            .dn_valid (stage_valid[k]),
            .dn_data  (stage_data[k])
         );
      end
   endgenerate

   assign req_stall = !stage_en[0];

   // result from the last stage register
   assign rsp_valid              = stage_valid[F];
   assign rsp_payload.hue        = stage_data[F].hue_quo;
   assign rsp_payload.saturation = stage_data[F].sat_quo;
   assign rsp_payload.brightness = stage_data[F].brightness;

endmodule

>>> design/rhc_front.sv
`timescale 1ns / 1ps

module rhc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  up_valid,
   input  rhc_pkg::rhc_req_type  up_data,
   output logic                  dn_valid,
   output rhc_pkg::rhc_stage_type dn_data
);

   localparam int C = rhc_pkg::CHANNEL_BITS;
   localparam int H = rhc_pkg::HUE_DIV_BITS;

   logic                   red_top;
   logic                   green_top;
   logic [C-1:0]           top;
   logic [C-1:0]           bottom;
   logic [C-1:0]           delta;
   logic [H-1:0]           delta_ext;
   logic [H-1:0]           turn;
   logic [H-1:0]           num;
   logic                   sat_first;
   logic                   valid_in;
   logic                   valid_ff;
   rhc_pkg::rhc_stage_type stage_in;
   rhc_pkg::rhc_stage_type stage_ff;

   // largest and smallest channel, ties go to red then green
   always_comb begin
      red_top   = (up_data.red >= up_data.green) && (up_data.red >= up_data.blue);
      green_top = !red_top && (up_data.green >= up_data.blue);
      if (red_top) begin
         top = up_data.red;
      end else if (green_top) begin
         top = up_data.green;
      end else begin
         top = up_data.blue;
      end
      if ((up_data.red <= up_data.green) && (up_data.red <= up_data.blue)) begin
         bottom = up_data.red;
      end else if (up_data.green <= up_data.blue) begin
         bottom = up_data.green;
      end else begin
         bottom = up_data.blue;
      end
      delta     = top - bottom;
      delta_ext = H'(delta);
      turn      = H'(delta_ext * H'(rhc_pkg::TURN_SECTORS));
   end

   // hue numerator, kept in [0, turn) by wrapping a negative red sector
   always_comb begin
      if (red_top) begin
         if (up_data.green >= up_data.blue) begin
            num = H'(up_data.green) - H'(up_data.blue);
         end else begin
            num = turn - (H'(up_data.blue) - H'(up_data.green));
         end
      end else if (green_top) begin
         num = (delta_ext << 1) + H'(up_data.blue) - H'(up_data.red);
      end else begin
         num = (delta_ext << 2) + H'(up_data.red) - H'(up_data.green);
      end
   end

   // leading saturation bit: delta equals top only when min is zero
   assign sat_first = (bottom == '0) && (top != '0);

   // seed both dividers; a zero divisor is replaced so black and grey give zero
   always_comb begin
      stage_in.brightness = top;
      stage_in.sat_div    = (top == '0) ? C'(1) : top;
      stage_in.sat_rem    = sat_first ? '0 : delta;
      stage_in.sat_quo    = (rhc_pkg::FRACTION_BITS + 1)'(sat_first);
      stage_in.hue_div    = (delta == '0) ? H'(rhc_pkg::TURN_SECTORS) : turn;
      stage_in.hue_rem    = num;
      stage_in.hue_quo    = '0;
   end

   assign valid_in = enable ? up_valid : valid_ff;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && up_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = stage_ff;

endmodule

>>> design/rhc_div_step.sv
`timescale 1ns / 1ps

module rhc_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   up_valid,
   input  rhc_pkg::rhc_stage_type up_data,
   output logic                   dn_valid,
   output rhc_pkg::rhc_stage_type dn_data
);

   localparam int C = rhc_pkg::CHANNEL_BITS;
   localparam int F = rhc_pkg::FRACTION_BITS;
   localparam int H = rhc_pkg::HUE_DIV_BITS;

   logic [C:0]             sat_trial;
   logic [C:0]             sat_diff;
   logic                   sat_bit;
   logic [H:0]             hue_trial;
   logic [H:0]             hue_diff;
   logic                   hue_bit;
   logic                   valid_in;
   logic                   valid_ff;
   rhc_pkg::rhc_stage_type stage_in;
   rhc_pkg::rhc_stage_type stage_ff;

   // one restoring step of the saturation division
   always_comb begin
      sat_trial = {up_data.sat_rem, 1'b0};
      sat_diff  = sat_trial - {1'b0, up_data.sat_div};
      sat_bit   = sat_trial >= {1'b0, up_data.sat_div};
   end

   // one restoring step of the hue division
   always_comb begin
      hue_trial = {up_data.hue_rem, 1'b0};
      hue_diff  = hue_trial - {1'b0, up_data.hue_div};
      hue_bit   = hue_trial >= {1'b0, up_data.hue_div};
   end

   // shift in the new quotient bits, keep the remainders below the divisors
   always_comb begin
      stage_in         = up_data;
      stage_in.sat_rem = sat_bit ? sat_diff[C-1:0] : sat_trial[C-1:0];
      stage_in.sat_quo = {up_data.sat_quo[F-1:0], sat_bit};
      stage_in.hue_rem = hue_bit ? hue_diff[H-1:0] : hue_trial[H-1:0];
      stage_in.hue_quo = {up_data.hue_quo[F-2:0], hue_bit};
   end

   assign valid_in = enable ? up_valid : valid_ff;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && up_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = stage_ff;

endmodule

>>> design/rhc_checker.sv
`timescale 1ns / 1ps

module rhc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input rhc_pkg::rhc_req_type req_payload,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rhc_pkg::rhc_rsp_type rsp_payload
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // a stalled request stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("request changed while stalled");

   // pipe is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input only backs up when the output is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipe");

   // black pixel gives all zeros
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.brightness == '0) |->
         (rsp_payload.hue == '0) && (rsp_payload.saturation == '0))
      else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_converter_top rhc_checker u_rhc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
